FILE: sv/gvc_pkg.sv
package gvc_pkg;

  localparam int unsigned POS_W   = 14;
  localparam int unsigned DIST_W  = 15;
  localparam int unsigned FIX_W   = 16;
  localparam int unsigned STEP_W  = 8;
  localparam int unsigned IDX_W   = 12;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned FRAC_BITS = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VIEW_RANGE   = 2'd0,
    REG_COS_HALF_FOV = 2'd1,
    REG_STEP_LENGTH  = 2'd2,
    REG_NONE         = 2'd3
  } cfg_reg_t;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic visible;
    logic within_range;
    logic within_cone;
    logic wall_blocked;
    logic [DIST_W-1:0] distance;
  } result_t;

endpackage

FILE: sv/grid_view_cone_visibility_core.sv
// Channel | Direction | Handshake            | Payload
// in_     | input     | in_valid / in_ready  | op, cell, wall bit, points, facing
// out_    | output    | out_valid/ out_ready | visible, flags, distance
// cfg_    | input     | cfg_we               | cfg_index, cfg_data
//
// Steps: a map write goes straight to the hand-over. A query forms the squares
// and dot products, takes the square root and runs the range and cone tests;
// unless the distance is zero or a test fails, it then runs the two increment
// divisions, then marches (step, one wall-map read, check per point), up to
// view_range / step_length points, and last hands the result over.
// Reset: clears control; then a clearing pass steps through every map cell
// and sets it to wall while in_ready stays low.
// Stalls: the output register holds until out_ready; the next item is taken
// while a result still waits, and a second result holds in the last state.
module grid_view_cone_visibility_core #(
  parameter int unsigned MAP_COLS   = 64,
  parameter int unsigned MAP_ROWS   = 64,
  parameter int unsigned CELL_SHIFT = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [gvc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gvc_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  logic [gvc_pkg::IDX_W-1:0]     in_cell_index,
  input  logic                          in_wall_bit,
  input  logic [gvc_pkg::POS_W-1:0]     in_observer_x,
  input  logic [gvc_pkg::POS_W-1:0]     in_observer_y,
  input  logic [gvc_pkg::POS_W-1:0]     in_target_x,
  input  logic [gvc_pkg::POS_W-1:0]     in_target_y,
  input  logic signed [gvc_pkg::FIX_W-1:0] in_facing_cos,
  input  logic signed [gvc_pkg::FIX_W-1:0] in_facing_sin,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_visible,
  output logic                          out_within_range,
  output logic                          out_within_cone,
  output logic                          out_wall_blocked,
  output logic [gvc_pkg::DIST_W-1:0]    out_distance
);

  localparam int unsigned CELLS   = MAP_COLS * MAP_ROWS;
  localparam int unsigned ADDR_W  = $clog2(CELLS);
  localparam int unsigned GX_W    = $clog2(MAP_COLS);
  localparam int unsigned GY_W    = $clog2(MAP_ROWS);
  localparam int unsigned CSHIFT  = gvc_pkg::FRAC_BITS + CELL_SHIFT;
  // Point accumulators: position plus fraction plus sign and headroom.
  localparam int unsigned ACC_W   = gvc_pkg::POS_W + gvc_pkg::FRAC_BITS + 3;
  localparam int unsigned NUM_W   = gvc_pkg::POS_W + gvc_pkg::STEP_W
                                    + gvc_pkg::FRAC_BITS;
  localparam int unsigned SQ_W    = 2 * gvc_pkg::POS_W + 1;
  localparam int unsigned DOT_W   = 2 * gvc_pkg::FIX_W + 2;
  localparam int unsigned HI_W    = ACC_W - CSHIFT;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SQUARE, S_SQRT, S_DOT, S_DIVX, S_DIVY,
    S_STEP, S_READ, S_CHECK, S_DONE
  } state_t;

  state_t state_r;

  // Configuration registers
  logic [gvc_pkg::DIST_W-1:0]        view_range_r;
  logic signed [gvc_pkg::FIX_W-1:0]  cos_half_fov_r;
  logic [gvc_pkg::STEP_W-1:0]        step_length_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_range_r   <= gvc_pkg::DIST_W'(1280);
      cos_half_fov_r <= gvc_pkg::FIX_W'(11585);
      step_length_r  <= gvc_pkg::STEP_W'(77);
    end else if (cfg_we) begin
      unique case (gvc_pkg::cfg_reg_t'(cfg_index))
        gvc_pkg::REG_VIEW_RANGE:   view_range_r   <= cfg_data[gvc_pkg::DIST_W-1:0];
        gvc_pkg::REG_COS_HALF_FOV: cos_half_fov_r <= cfg_data;
        gvc_pkg::REG_STEP_LENGTH:  step_length_r  <= cfg_data[gvc_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Working registers
  logic signed [gvc_pkg::POS_W:0]   dx_r, dy_r;
  logic [gvc_pkg::POS_W-1:0]        ox_r, oy_r;
  logic signed [gvc_pkg::FIX_W-1:0] fc_r, fs_r;
  logic [SQ_W-1:0]                  rem_r;
  logic [SQ_W-1:0]                  root_r;
  logic [SQ_W:0]                    bit_r;
  logic signed [DOT_W-1:0]          px_r, py_r;
  logic signed [DOT_W-1:0]          lim_r;
  logic [gvc_pkg::DIST_W-1:0]       dist_r;
  logic [gvc_pkg::STEP_W-1:0]       step_r;
  logic [NUM_W-1:0]                 incx_r, incy_r;
  logic signed [ACC_W-1:0]          ax_r, ay_r;
  logic [gvc_pkg::DIST_W+1:0]       t_r;
  logic                             in_range_r;
  logic [ADDR_W-1:0]                clr_r;
  logic [NUM_W-1:0]                 num_r;
  logic                             div_start_r;
  logic                             div_done;
  logic [NUM_W-1:0]                 div_quo;
  logic                             oob_r;
  gvc_pkg::result_t                 res_r;
  gvc_pkg::result_t                 out_res_r;
  logic                             out_valid_r;

  // Map RAM port
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic              ram_wdata, ram_rdata;

  gvc_ram #(.WIDTH(1), .DEPTH(CELLS)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  gvc_divider #(.NUM_W(NUM_W), .DEN_W(gvc_pkg::DIST_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start_r),
    .num   (num_r),
    .den   (dist_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  logic accept;
  logic can_emit;
  assign can_emit = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Map write on a write item with a cell index inside the map, or during the clearing pass.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_r;
    ram_wdata = 1'b1;
    if (state_r == S_CLEAR) begin
      ram_we = 1'b1;
    end else if (accept && in_op == gvc_pkg::OP_WRITE
                 && 32'(in_cell_index) < CELLS) begin
      ram_we    = 1'b1;
      ram_waddr = ADDR_W'(in_cell_index);
      ram_wdata = in_wall_bit;
    end
  end

  // March point to cell.
  logic [HI_W-1:0] gx_hi, gy_hi;
  logic            pt_oob;
  always_comb begin
    gx_hi  = HI_W'(ax_r >>> CSHIFT);
    gy_hi  = HI_W'(ay_r >>> CSHIFT);
    pt_oob = ax_r[ACC_W-1] || ay_r[ACC_W-1]
             || 32'(gx_hi) >= MAP_COLS || 32'(gy_hi) >= MAP_ROWS;
    ram_raddr = ADDR_W'(32'(gy_hi[GY_W-1:0]) * MAP_COLS + 32'(gx_hi[GX_W-1:0]));
  end

  logic [SQ_W:0] trial;
  assign trial = {1'b0, root_r} + bit_r;

  logic signed [ACC_W-1:0] incx_s, incy_s;
  assign incx_s = dx_r[gvc_pkg::POS_W] ? -$signed(ACC_W'(incx_r)) : $signed(ACC_W'(incx_r));
  assign incy_s = dy_r[gvc_pkg::POS_W] ? -$signed(ACC_W'(incy_r)) : $signed(ACC_W'(incy_r));

  logic [gvc_pkg::POS_W-1:0] adx, ady;
  assign adx = dx_r[gvc_pkg::POS_W] ? gvc_pkg::POS_W'(-dx_r) : gvc_pkg::POS_W'(dx_r);
  assign ady = dy_r[gvc_pkg::POS_W] ? gvc_pkg::POS_W'(-dy_r) : gvc_pkg::POS_W'(dy_r);

  logic signed [DOT_W-1:0] dot;
  assign dot = px_r + py_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      div_start_r <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      // Raise valid when a result moves to the output, drop it after a transfer.
      if (state_r == S_DONE && can_emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (32'(clr_r) == CELLS - 1) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            if (in_op == gvc_pkg::OP_WRITE) begin
              res_r   <= '0;
              state_r <= S_DONE;
            end else begin
              ox_r    <= in_observer_x;
              oy_r    <= in_observer_y;
              dx_r    <= $signed({1'b0, in_target_x}) - $signed({1'b0, in_observer_x});
              dy_r    <= $signed({1'b0, in_target_y}) - $signed({1'b0, in_observer_y});
              fc_r    <= in_facing_cos;
              fs_r    <= in_facing_sin;
              state_r <= S_SQUARE;
            end
          end
        end
        S_SQUARE: begin
          rem_r   <= SQ_W'(32'(adx) * 32'(adx) + 32'(ady) * 32'(ady));
          root_r  <= '0;
          bit_r   <= (SQ_W + 1)'(1) << (SQ_W - 1);
          px_r    <= DOT_W'(32'(dx_r) * 32'(fc_r));
          py_r    <= DOT_W'(32'(dy_r) * 32'(fs_r));
          state_r <= S_SQRT;
        end
        S_SQRT: begin
          // One result bit per cycle, same recurrence as the digit method.
          if (bit_r == '0) begin
            dist_r  <= gvc_pkg::DIST_W'(root_r);
            state_r <= S_DOT;
          end else begin
            if ({1'b0, rem_r} >= trial) begin
              rem_r  <= SQ_W'({1'b0, rem_r} - trial);
              root_r <= SQ_W'((root_r >> 1) + SQ_W'(bit_r));
            end else begin
              root_r <= root_r >> 1;
            end
            bit_r <= bit_r >> 2;
          end
        end
        S_DOT: begin
          lim_r      <= DOT_W'(32'($signed({1'b0, dist_r})) * 32'(cos_half_fov_r));
          in_range_r <= dist_r <= view_range_r;
          step_r     <= (step_length_r == '0) ? gvc_pkg::STEP_W'(1) : step_length_r;
          state_r    <= S_DIVX;
          num_r      <= NUM_W'(32'(adx) * 32'(step_length_r == '0 ? 8'd1 : step_length_r))
                        << gvc_pkg::FRAC_BITS;
          div_start_r <= 1'b0;
          oob_r      <= 1'b0;
        end
        S_DIVX: begin
          if (!oob_r) begin
            oob_r     <= 1'b1;
            if (dist_r == '0) begin
              res_r   <= '{visible: 1'b1, within_range: 1'b1, within_cone: 1'b1,
                           wall_blocked: 1'b0, distance: dist_r};
              state_r <= S_DONE;
            end else if (!in_range_r || dot < lim_r) begin
              res_r   <= '{visible: 1'b0, within_range: in_range_r,
                           within_cone: dot >= lim_r, wall_blocked: 1'b0,
                           distance: dist_r};
              state_r <= S_DONE;
            end else begin
              div_start_r <= 1'b1;
            end
          end else if (div_done) begin
            incx_r      <= div_quo;
            num_r       <= NUM_W'(32'(ady) * 32'(step_r)) << gvc_pkg::FRAC_BITS;
            div_start_r <= 1'b1;
            state_r     <= S_DIVY;
          end
        end
        S_DIVY: begin
          if (div_done && !div_start_r) begin
            incy_r  <= div_quo;
            ax_r    <= ACC_W'({ox_r, gvc_pkg::FRAC_BITS'(0)});
            ay_r    <= ACC_W'({oy_r, gvc_pkg::FRAC_BITS'(0)});
            t_r     <= (gvc_pkg::DIST_W + 2)'(step_r);
            state_r <= S_STEP;
          end
        end
        S_STEP: begin
          if (t_r >= (gvc_pkg::DIST_W + 2)'(dist_r)) begin
            res_r   <= '{visible: 1'b1, within_range: 1'b1, within_cone: 1'b1,
                         wall_blocked: 1'b0, distance: dist_r};
            state_r <= S_DONE;
          end else begin
            ax_r    <= ax_r + incx_s;
            ay_r    <= ay_r + incy_s;
            t_r     <= t_r + (gvc_pkg::DIST_W + 2)'(step_r);
            state_r <= S_READ;
          end
        end
        S_READ: begin
          oob_r   <= pt_oob;
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          if (oob_r || ram_rdata) begin
            res_r   <= '{visible: 1'b0, within_range: 1'b1, within_cone: 1'b1,
                         wall_blocked: 1'b1, distance: dist_r};
            state_r <= S_DONE;
          end else begin
            state_r <= S_STEP;
          end
        end
        S_DONE: begin
          // Hold until the output register is free, then hand the result over.
          if (can_emit) begin
            out_res_r <= res_r;
            state_r   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_visible      = out_res_r.visible;
  assign out_within_range = out_res_r.within_range;
  assign out_within_cone  = out_res_r.within_cone;
  assign out_wall_blocked = out_res_r.wall_blocked;
  assign out_distance     = out_res_r.distance;

`ifndef ASSERT_OFF
  a_vis_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_visible |-> out_within_range && out_within_cone && !out_wall_blocked)
    else $error("visible set with a failed test");
  a_no_take_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> !in_ready)
    else $error("input taken during map clear");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_distance))
    else $error("result dropped while stalled");
`endif

endmodule

FILE: sv/gvc_ram.sv
module gvc_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/gvc_divider.sv
// Unsigned restoring divider, one quotient bit per cycle.
module gvc_divider #(
  parameter int unsigned NUM_W = 37,
  parameter int unsigned DEN_W = 15
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_r;
  logic [DEN_W:0]   rem_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W+1:0] diff;

  always_comb begin
    trial = {rem_r[DEN_W-1:0], quo_r[NUM_W-1]};
    diff  = {1'b0, trial} - {2'b00, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
        quo_r  <= num;
        rem_r  <= '0;
        den_r  <= den;
      end else if (busy_r) begin
        if (!diff[DEN_W+1]) begin
          rem_r <= diff[DEN_W:0];
          quo_r <= {quo_r[NUM_W-2:0], 1'b1};
        end else begin
          rem_r <= trial;
          quo_r <= {quo_r[NUM_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  assign quo = quo_r;

endmodule

FILE: tb/sv/tb_grid_view_cone_visibility_core.sv
module tb_grid_view_cone_visibility_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAP_COLS    = 64;
  localparam int MAP_ROWS    = 64;
  localparam int CELL_SHIFT  = 8;
  localparam int STALL_LIMIT = 200000;  // covers the map clearing pass and a full-range march
  localparam int SETTLE      = 40;

  typedef struct {
    logic                             op;
    logic [gvc_pkg::IDX_W-1:0]        cell_idx;
    logic                             wall;
    logic [gvc_pkg::POS_W-1:0]        ox, oy, tx, ty;
    logic signed [gvc_pkg::FIX_W-1:0] fc, fs;
  } sight_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [gvc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [gvc_pkg::CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_op = gvc_pkg::OP_WRITE;
  logic [gvc_pkg::IDX_W-1:0] in_cell_index = '0;
  logic in_wall_bit = 1'b0;
  logic [gvc_pkg::POS_W-1:0] in_observer_x = '0, in_observer_y = '0;
  logic [gvc_pkg::POS_W-1:0] in_target_x = '0, in_target_y = '0;
  logic signed [gvc_pkg::FIX_W-1:0] in_facing_cos = '0, in_facing_sin = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_visible, out_within_range, out_within_cone, out_wall_blocked;
  logic [gvc_pkg::DIST_W-1:0] out_distance;

  // Shadow state of the block
  logic                             wall_map [MAP_COLS*MAP_ROWS];
  logic [gvc_pkg::DIST_W-1:0]       range_reg;
  logic signed [gvc_pkg::FIX_W-1:0] cos_reg;
  logic [gvc_pkg::STEP_W-1:0]       step_reg;

  sight_item_t      pending_items[$];
  gvc_pkg::result_t expected_sightings[$];
  sight_item_t      drv_item;
  bit               took = 1'b0;
  int               send_idle_pct = 0;
  int               stall_pct = 0;
  int               mismatches = 0;
  int               quiet_cycles = 0;

  grid_view_cone_visibility_core #(
    .MAP_COLS(MAP_COLS), .MAP_ROWS(MAP_ROWS), .CELL_SHIFT(CELL_SHIFT)
  ) i_dut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .in_op, .in_cell_index, .in_wall_bit,
    .in_observer_x, .in_observer_y, .in_target_x, .in_target_y,
    .in_facing_cos, .in_facing_sin,
    .out_valid, .out_ready, .out_visible, .out_within_range, .out_within_cone,
    .out_wall_blocked, .out_distance
  );

  always #1 clk = ~clk;

  function automatic longint floor_sqrt(longint n);
    longint r = 0;
    longint b = 64'd1 << 30;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Per-step increment with 8 fraction bits, truncated toward zero
  function automatic longint march_inc(longint d, longint stp, longint span);
    longint q;
    q = ((d < 0 ? -d : d) * stp * (64'd1 << gvc_pkg::FRAC_BITS)) / span;
    return d < 0 ? -q : q;
  endfunction

  function automatic bit wall_at(longint px, longint py);
    longint gx, gy;
    if (px < 0 || py < 0) return 1'b1;
    gx = px >>> (gvc_pkg::FRAC_BITS + CELL_SHIFT);
    gy = py >>> (gvc_pkg::FRAC_BITS + CELL_SHIFT);
    if (gx >= MAP_COLS || gy >= MAP_ROWS) return 1'b1;
    return wall_map[gy*MAP_COLS + gx];
  endfunction

  // Apply one accepted item to the shadow map and return its sighting
  function automatic gvc_pkg::result_t predict_sighting(sight_item_t it);
    gvc_pkg::result_t r;
    longint dx, dy, span, dot, lim, stp, ix, iy, px, py, t;
    r = '0;
    if (it.op == gvc_pkg::OP_WRITE) begin
      if (it.cell_idx < MAP_COLS*MAP_ROWS) wall_map[it.cell_idx] = it.wall;
      return r;
    end
    dx = longint'(it.tx) - longint'(it.ox);
    dy = longint'(it.ty) - longint'(it.oy);
    span = floor_sqrt(dx*dx + dy*dy);
    dot = dx*longint'(it.fc) + dy*longint'(it.fs);
    lim = span*longint'(cos_reg);
    r.distance = span[gvc_pkg::DIST_W-1:0];
    r.within_range = (span <= longint'(range_reg));
    r.within_cone = (dot >= lim);
    if (span == 0) begin
      r.within_range = 1'b1;
      r.within_cone = 1'b1;
      r.visible = 1'b1;
    end else if (r.within_range && r.within_cone) begin
      stp = (step_reg == 0) ? 1 : longint'(step_reg);
      ix = march_inc(dx, stp, span);
      iy = march_inc(dy, stp, span);
      px = longint'(it.ox) << gvc_pkg::FRAC_BITS;
      py = longint'(it.oy) << gvc_pkg::FRAC_BITS;
      for (t = stp; t < span; t += stp) begin
        px += ix;
        py += iy;
        if (wall_at(px, py)) begin
          r.wall_blocked = 1'b1;
          break;
        end
      end
      r.visible = !r.wall_blocked;
    end
    return r;
  endfunction

  function automatic sight_item_t map_write(int idx, bit w);
    sight_item_t it = '{default: '0};
    it.op = gvc_pkg::OP_WRITE;
    it.cell_idx = gvc_pkg::IDX_W'(idx);
    it.wall = w;
    return it;
  endfunction

  function automatic sight_item_t sight_query(int ox, int oy, int tx, int ty, int fc, int fs);
    sight_item_t it = '{default: '0};
    it.op = gvc_pkg::OP_QUERY;
    it.ox = gvc_pkg::POS_W'(ox); it.oy = gvc_pkg::POS_W'(oy);
    it.tx = gvc_pkg::POS_W'(tx); it.ty = gvc_pkg::POS_W'(ty);
    it.fc = gvc_pkg::FIX_W'(fc); it.fs = gvc_pkg::FIX_W'(fs);
    return it;
  endfunction

  function automatic int clamp_pos(int v);
    return v < 0 ? 0 : (v > 16383 ? 16383 : v);
  endfunction

  // Append one item to the driver's queue
  task automatic queue_item(sight_item_t it);
    pending_items.insert(pending_items.size(), it);
  endtask

  // Hot region of cells 20..35 gets cleared and probed so that marches run deep
  task automatic queue_random(int count);
    sight_item_t it;
    int ox, oy, rad, pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        it = map_write((20 + $urandom_range(15))*MAP_COLS + 20 + $urandom_range(15),
                       $urandom_range(99) < 20);
      end else if (pick < 42) begin
        it = map_write($urandom_range(4095), $urandom_range(1));
      end else begin
        if ($urandom_range(99) < 75) begin
          ox = 5120 + $urandom_range(4095);
          oy = 5120 + $urandom_range(4095);
        end else begin
          ox = $urandom_range(16383);
          oy = $urandom_range(16383);
        end
        rad = ($urandom_range(9) == 0) ? 16383 : $urandom_range(1500);
        it = sight_query(ox, oy,
                         clamp_pos(ox + $urandom_range(2*rad) - rad),
                         clamp_pos(oy + $urandom_range(2*rad) - rad), 0, 0);
        case ($urandom_range(3))
          0: begin
            it.fc = gvc_pkg::FIX_W'($urandom_range(32768) - 16384);
            it.fs = gvc_pkg::FIX_W'($urandom_range(32768) - 16384);
          end
          default: begin
            // aim roughly at the target so the cone test passes often
            it.fc = gvc_pkg::FIX_W'((longint'(it.tx) - ox) * 8);
            it.fs = gvc_pkg::FIX_W'((longint'(it.ty) - oy) * 8);
            if (it.tx > ox + 2048) it.fc = gvc_pkg::FIX_W'(16384);
            if (it.tx + 2048 < ox) it.fc = gvc_pkg::FIX_W'(-16384);
            if (it.ty > oy + 2048) it.fs = gvc_pkg::FIX_W'(16384);
            if (it.ty + 2048 < oy) it.fs = gvc_pkg::FIX_W'(-16384);
          end
        endcase
      end
      queue_item(it);
    end
  endtask

  // Write one register while the block is idle
  task automatic write_reg(gvc_pkg::cfg_reg_t idx, int val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[gvc_pkg::CFG_W-1:0];
    case (idx)
      gvc_pkg::REG_VIEW_RANGE:   range_reg = val[gvc_pkg::DIST_W-1:0];
      gvc_pkg::REG_COS_HALF_FOV: cos_reg = val[gvc_pkg::FIX_W-1:0];
      gvc_pkg::REG_STEP_LENGTH:  step_reg = val[gvc_pkg::STEP_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold the sender until every expected sighting has come back
  task automatic drain;
    while (pending_items.size() != 0 || in_valid || expected_sightings.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic run_phase(int rng, int cosv, int stp, int sidle, int stall, int count);
    write_reg(gvc_pkg::REG_VIEW_RANGE, rng);
    write_reg(gvc_pkg::REG_COS_HALF_FOV, cosv);
    write_reg(gvc_pkg::REG_STEP_LENGTH, stp);
    send_idle_pct = sidle;
    stall_pct = stall;
    queue_random(count);
    drain();
  endtask

  // Driver: advance to the next item after each transfer, idle at random
  always @(negedge clk) begin
    out_ready <= rst_n && ($urandom_range(99) >= stall_pct);
    if (rst_n && (!in_valid || took)) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drv_item = pending_items.pop_front();
        in_op <= drv_item.op;
        in_cell_index <= drv_item.cell_idx;
        in_wall_bit <= drv_item.wall;
        in_observer_x <= drv_item.ox;
        in_observer_y <= drv_item.oy;
        in_target_x <= drv_item.tx;
        in_target_y <= drv_item.ty;
        in_facing_cos <= drv_item.fc;
        in_facing_sin <= drv_item.fs;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: predict on each input transfer, check each output transfer
  always @(posedge clk) begin
    gvc_pkg::result_t got, want;
    took = rst_n && in_valid && in_ready;
    if (took) expected_sightings.insert(expected_sightings.size(), predict_sighting(drv_item));
    if (rst_n && out_valid && out_ready) begin
      got = '{out_visible, out_within_range, out_within_cone, out_wall_blocked, out_distance};
      if (expected_sightings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected sighting %p", got);
      end else begin
        want = expected_sightings.pop_front();
        if (got.visible !== want.visible || got.within_range !== want.within_range ||
            got.within_cone !== want.within_cone ||
            got.wall_blocked !== want.wall_blocked || got.distance !== want.distance) begin
          mismatches++;
          if (mismatches <= 10) $display("sighting mismatch: expected %p, got %p", want, got);
        end
      end
    end
    // Watchdog: count cycles with no transfer on either channel
    if (took || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < MAP_COLS*MAP_ROWS; i++) wall_map[i] = 1'b1;
    range_reg = gvc_pkg::DIST_W'(1280);
    cos_reg = gvc_pkg::FIX_W'(11585);
    step_reg = gvc_pkg::STEP_W'(77);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: open a short corridor at row 10, columns 10..12, and cell 0
    queue_item(map_write(650, 1'b0));
    queue_item(map_write(651, 1'b0));
    queue_item(map_write(652, 1'b0));
    queue_item(map_write(0, 1'b0));
    queue_item(map_write(4095, 1'b0));
    queue_item(map_write(4095, 1'b1));
    queue_item(sight_query(2688, 2688, 2688, 2688, 0, 0));        // zero distance
    queue_item(sight_query(2688, 2688, 3200, 2688, 16384, 0));    // clear corridor
    queue_item(sight_query(2688, 2688, 3700, 2688, 16384, 0));    // hits a wall
    queue_item(sight_query(2688, 2688, 3200, 2688, -16384, 0));   // behind observer
    queue_item(sight_query(2688, 2688, 4688, 2688, 16384, 0));    // past range
    queue_item(sight_query(0, 0, 16383, 16383, 11585, 11585));
    queue_item(sight_query(16383, 16383, 0, 0, -16384, -16384));
    queue_item(sight_query(100, 100, 200, 200, 16384, 16384));    // long facing
    queue_item(sight_query(200, 200, 100, 100, -11585, -11585));
    queue_item(sight_query(2688, 2688, 2688, 3200, 0, 16384));    // blocked north
    queue_item(sight_query(3200, 2688, 2688, 2688, -1, 0));       // tiny facing
    queue_item(map_write(651, 1'b1));
    queue_item(sight_query(2688, 2688, 3200, 2688, 16384, 0));    // now blocked
    queue_random(270);
    drain();

    run_phase(23170, -16384, 255, 55, 0, 250);
    run_phase(0, 16384, 1, 0, 55, 150);
    run_phase(400, 0, 0, 7, 7, 60);
    run_phase(500 + $urandom_range(2500), $urandom_range(32768) - 16384,
              20 + $urandom_range(235), 0, 55, 200);

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/gvc_pkg.sv
sv/gvc_ram.sv
sv/gvc_divider.sv
sv/grid_view_cone_visibility_core.sv
tb/sv/tb_grid_view_cone_visibility_core.sv
